>>> rtl/bbc_pkg.sv
package bbc_pkg;

  localparam int BLOCK_BITS = 16;
  localparam int WAY_BITS = 3;
  localparam int BANK_BITS = 2;
  localparam int WAYS = 8;
  localparam int ENTRIES = 32;
  localparam int SLOT_BITS = 5;

  localparam logic [9:0] AGE_FRESH = 10'd1000;
  localparam logic [9:0] AGE_PREFETCH = 10'd250;
  localparam logic [9:0] STREAK_MAX = 10'd1000;
  localparam logic [49:0] NEAR_GAP = 50'd8192;
  localparam logic [16:0] BLOCK_LEN = 17'd65536;

  localparam logic [1:0] ST_HIT = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_BYPASS = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  localparam logic CFG_IMAGE_SIZE = 1'b0;
  localparam logic CFG_PREFETCH = 1'b1;

  typedef struct packed {
    logic [47:0] req_offset;
    logic [16:0] req_length;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  slot;
    logic [47:0] block_offset;
    logic [16:0] fill_length;
    logic [15:0] byte_in_block;
    logic [16:0] byte_count;
    logic        prefetch_valid;
    logic [4:0]  prefetch_slot;
    logic [47:0] prefetch_offset;
    logic [16:0] prefetch_length;
  } out_item_t;

endpackage

>>> rtl/banked_block_cache_with_prefetch_unit.sv
// A request beyond the image or crossing a block goes through check and finish; a hit
// goes through check, 8 lookup steps and finish; a miss adds a fill, and a miss with a
// read-ahead scan also adds 8 scan steps and a read-ahead write before the finish.
// One request at a time: the next is taken the cycle after the finish cycle, and the
// finish waits while an earlier result is still held by out_stall.
// Reset (rst_n low, synchronous) clears all entries, bank history and the output.
module banked_block_cache_with_prefetch_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bbc_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output bbc_pkg::out_item_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [48:0]       cfg_wdata
);
  import bbc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_LOOK = 3'd2;
  localparam logic [2:0] S_FILL = 3'd3;
  localparam logic [2:0] S_PF = 3'd4;
  localparam logic [2:0] S_PFW = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [48:0] image_size_r;
  logic prefetch_enable_r;

  logic [47:0] tag_r [ENTRIES];
  logic [16:0] fill_r [ENTRIES];
  logic [9:0]  age_r [ENTRIES];
  logic [47:0] prev_off_r [4];
  logic [16:0] prev_cnt_r [4];
  logic [9:0]  streak_r [4];

  logic [47:0] off_r;
  logic [16:0] len_r, len2_r;
  logic [BANK_BITS-1:0] bank_r;
  logic [WAY_BITS-1:0] way_r, next_r, ra_r;
  logic hit_r, cached_r, have_r, have_unused_r;
  logic [4:0] hit_slot_r;
  out_item_t res_r;
  out_item_t result_r;
  logic out_valid_r;

  logic [47:0] blk_base;
  logic [48:0] rem_img;
  logic [16:0] len2_c;
  logic [4:0] gi, gnext, gra;
  logic [47:0] ra_off;
  logic [48:0] rem_ra, rem_blk;
  logic [49:0] expected;
  logic seq;
  logic [9:0] aged;
  logic [16:0] within17;
  logic [17:0] wsum;
  logic look_hit;
  logic [16:0] fsize_c, len2_fill_c;

  assign blk_base = {off_r[47:BLOCK_BITS], {BLOCK_BITS{1'b0}}};
  assign within17 = {1'b0, off_r[BLOCK_BITS-1:0]};
  assign rem_img = image_size_r - {1'b0, off_r};
  assign len2_c = (rem_img < {32'd0, len_r}) ? rem_img[16:0] : len_r;
  assign gi = {bank_r, way_r};
  assign gnext = {bank_r, next_r};
  assign gra = {bank_r, ra_r};
  assign ra_off = blk_base + 48'd65536;
  assign rem_ra = image_size_r - {1'b0, ra_off};
  assign rem_blk = image_size_r - {1'b0, blk_base};
  assign expected = {2'b0, prev_off_r[bank_r]} + {33'd0, prev_cnt_r[bank_r]};
  assign seq = (off_r >= prev_off_r[bank_r]) &&
               (({2'b0, off_r} == expected) ||
                (({2'b0, off_r} > expected) && ({2'b0, off_r} < expected + NEAR_GAP)));
  assign aged = (age_r[gi] > 10'd1) ? age_r[gi] - 10'd1 : age_r[gi];
  assign wsum = {1'b0, within17} + {1'b0, len_r};
  assign look_hit = (fill_r[gi] != '0) && !hit_r && (tag_r[gi] == blk_base) &&
                    ({1'b0, tag_r[gi]} + {32'd0, fill_r[gi]} >=
                     {1'b0, off_r} + {32'd0, len2_r});
  assign fsize_c = (rem_blk < 49'd65536) ? rem_blk[16:0] : BLOCK_LEN;
  assign len2_fill_c = (within17 > fsize_c) ? 17'd0 :
                       (({1'b0, within17} + {1'b0, len2_r} > {1'b0, fsize_c}) ?
                        fsize_c - within17 : len2_r);

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = result_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_CHECK;
      S_CHECK: begin
        if ({1'b0, off_r} >= image_size_r || wsum > {1'b0, BLOCK_LEN}) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (way_r == WAY_BITS'(WAYS - 1)) state_nxt = (hit_r || look_hit) ? S_DONE : S_FILL;
      end
      S_FILL: begin
        if (prefetch_enable_r && streak_r[bank_r] >= 10'd2 &&
            {1'b0, ra_off} < image_size_r && ra_off[18:16] != 3'd0) begin
          state_nxt = S_PF;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_PF: if (way_r == WAY_BITS'(WAYS - 1)) state_nxt = S_PFW;
      S_PFW: state_nxt = S_DONE;
      S_DONE: if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      image_size_r <= '0;
      prefetch_enable_r <= 1'b1;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        tag_r[i] <= '0;
        fill_r[i] <= '0;
        age_r[i] <= '0;
      end
      for (int b = 0; b < 4; b++) begin
        prev_off_r[b] <= '0;
        prev_cnt_r[b] <= '0;
        streak_r[b] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_IMAGE_SIZE: image_size_r <= cfg_wdata;
          CFG_PREFETCH: prefetch_enable_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
        result_r <= res_r;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            off_r <= in_data.req_offset;
            len_r <= in_data.req_length;
            bank_r <= in_data.req_offset[20:19];
            res_r <= '0;
          end
        end
        S_CHECK: begin
          way_r <= '0;
          next_r <= '0;
          hit_r <= 1'b0;
          len2_r <= len2_c;
          if ({1'b0, off_r} >= image_size_r) begin
            res_r.status <= ST_RANGE;
          end else begin
            res_r.block_offset <= blk_base;
            res_r.byte_in_block <= off_r[15:0];
            if (wsum > {1'b0, BLOCK_LEN}) begin
              res_r.status <= ST_BYPASS;
              res_r.byte_count <= len2_c;
            end else begin
              if (seq) begin
                if (streak_r[bank_r] < STREAK_MAX)
                  streak_r[bank_r] <= streak_r[bank_r] + 10'd1;
              end else begin
                streak_r[bank_r] <= '0;
              end
              prev_off_r[bank_r] <= off_r;
            end
          end
        end
        S_LOOK: begin
          way_r <= way_r + WAY_BITS'(1);
          if (fill_r[gi] != '0) begin
            if (look_hit) begin
              hit_r <= 1'b1;
              hit_slot_r <= gi;
              age_r[gi] <= AGE_FRESH;
            end else begin
              age_r[gi] <= aged;
              if (fill_r[gnext] != '0 && aged < age_r[gnext]) next_r <= way_r;
            end
          end else begin
            next_r <= way_r;
          end
          if (way_r == WAY_BITS'(WAYS - 1) && hit_r) begin
            res_r.status <= ST_HIT;
            res_r.slot <= hit_slot_r;
            res_r.byte_count <= len2_r;
            prev_cnt_r[bank_r] <= len2_r;
          end else if (way_r == WAY_BITS'(WAYS - 1) && look_hit) begin
            res_r.status <= ST_HIT;
            res_r.slot <= gi;
            res_r.byte_count <= len2_r;
            prev_cnt_r[bank_r] <= len2_r;
          end
        end
        S_FILL: begin
          age_r[gnext] <= AGE_FRESH;
          fill_r[gnext] <= fsize_c;
          tag_r[gnext] <= blk_base;
          res_r.status <= ST_MISS;
          res_r.slot <= gnext;
          res_r.fill_length <= fsize_c;
          res_r.byte_count <= len2_fill_c;
          prev_cnt_r[bank_r] <= len2_fill_c;
          way_r <= '0;
          cached_r <= 1'b0;
          have_r <= 1'b0;
          have_unused_r <= 1'b0;
          ra_r <= '0;
        end
        S_PF: begin
          way_r <= way_r + WAY_BITS'(1);
          if (!cached_r) begin
            if (fill_r[gi] != '0 && tag_r[gi] == ra_off) begin
              cached_r <= 1'b1;
            end else if (way_r != next_r) begin
              if (fill_r[gi] == '0) begin
                if (!have_unused_r) begin
                  ra_r <= way_r;
                  have_r <= 1'b1;
                  have_unused_r <= 1'b1;
                end
              end else if (!have_unused_r && (!have_r || age_r[gi] < age_r[gra])) begin
                ra_r <= way_r;
                have_r <= 1'b1;
              end
            end
          end
        end
        S_PFW: begin
          if (!cached_r && have_r) begin
            tag_r[gra] <= ra_off;
            fill_r[gra] <= (rem_ra < 49'd65536) ? rem_ra[16:0] : BLOCK_LEN;
            age_r[gra] <= AGE_PREFETCH;
            res_r.prefetch_valid <= 1'b1;
            res_r.prefetch_slot <= gra;
            res_r.prefetch_offset <= ra_off;
            res_r.prefetch_length <= (rem_ra < 49'd65536) ? rem_ra[16:0] : BLOCK_LEN;
          end
        end
        default: ;
      endcase
    end
  end

  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOK) |-> in_stall) else $error("accepted while busy");
  a_out_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall) |=> !out_valid_r || (state_r == S_IDLE))
    else $error("result repeated");
  a_pf_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && result_r.prefetch_valid) |-> (result_r.status == ST_MISS))
    else $error("read-ahead without miss");

endmodule
